FILE: hw/rtl/ahcl_pkg.sv
package ahcl_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_E      = 8'h45;
  localparam logic [7:0] CHAR_R      = 8'h52;
  localparam logic [7:0] CHAR_O      = 8'h4F;

  localparam logic [1:0]  CFG_GAIN      = 2'd0;
  localparam logic [1:0]  CFG_INTENSITY = 2'd1;
  localparam logic [1:0]  CFG_RETRY     = 2'd2;

  localparam logic [15:0] GAIN_RESET  = 16'd256;
  localparam logic [3:0]  RETRY_RESET = 4'd2;

  localparam logic [2:0]  ERR_SEEN      = 3'd5;
  localparam logic [3:0]  REPLY_MAX     = 4'd15;
  localparam logic [3:0]  FRAME_LEN     = 4'd8;
  localparam logic [3:0]  REPLY_MIN     = 4'd3;
  localparam logic [3:0]  FAIL_COUNT    = 4'd2;
  localparam logic [23:0] PROD_ONE      = 24'd256;
  localparam logic [23:0] PROD_SAT      = 24'd65280;
  localparam logic [23:0] PROD_HALF     = 24'd128;

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_RX      = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ERROR     = 2'd1,
    STAT_UNKNOWN   = 2'd2,
    STAT_READ_FAIL = 2'd3
  } status_t;

  typedef enum logic {
    OUT_TX      = 1'b0,
    OUT_VERDICT = 1'b1
  } out_kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] address;
    logic [7:0] data;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    out_kind_t  out_kind;
    logic [7:0] tx_byte;
    status_t    status;
    logic       gave_up;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       verdict_en;
    status_t    status;
    logic       gave_up;
    logic       frame_en;
    logic [7:0] address;
    logic [7:0] data;
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n <= 4'd9) r = 8'h30 + {4'h0, n};
    else r = 8'h41 + {4'h0, n} - 8'd10;
    return r;
  endfunction

  function automatic logic [7:0] frame_byte(input logic [2:0] pos,
                                            input logic [7:0] addr,
                                            input logic [7:0] dat);
    logic [7:0] r;
    case (pos)
      3'd0: r = CHAR_DOLLAR;
      3'd1: r = CHAR_G;
      3'd2: r = hex_digit(addr[7:4]);
      3'd3: r = hex_digit(addr[3:0]);
      3'd4: r = hex_digit(dat[7:4]);
      3'd5: r = hex_digit(dat[3:0]);
      3'd6: r = CHAR_CR;
      default: r = CHAR_LF;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] error_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = CHAR_E;
      3'd1: r = CHAR_R;
      3'd2: r = CHAR_R;
      3'd3: r = CHAR_O;
      default: r = CHAR_R;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/ahcl_front.sv
module ahcl_front import ahcl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic [15:0] gain_r;
  logic [7:0]  int_addr_r;
  logic [3:0]  retry_r;

  logic [7:0] fa_r, fa_nxt;
  logic [7:0] fd_r, fd_nxt;
  logic       await_r, await_nxt;
  logic [3:0] att_r, att_nxt;
  logic [3:0] rc_r, rc_nxt;
  logic       em_r, em_nxt;
  logic [2:0] ems_r, ems_nxt;
  logic [7:0] prev_r, prev_nxt;

  logic        fire;
  logic [23:0] prod;
  logic [23:0] rounded;
  logic [7:0]  scaled;
  logic [7:0]  cmd_data;
  logic [7:0]  b;
  logic        g_em;
  logic [2:0]  g_ems;
  logic [3:0]  g_rc;
  logic        g_done;
  status_t     g_status;
  logic        do_gather;
  logic        do_verdict;
  status_t     v_status;
  logic [3:0]  lim;
  logic        final_v;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= GAIN_RESET;
      int_addr_r <= '0;
      retry_r    <= RETRY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GAIN:      gain_r     <= cfg_data;
        CFG_INTENSITY: int_addr_r <= cfg_data[7:0];
        CFG_RETRY:     retry_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign prod    = 24'(in_data.data) * 24'(gain_r);
  assign rounded = prod + PROD_HALF;
  always_comb begin
    if (prod != '0 && prod < PROD_ONE) scaled = 8'd1;
    else if (prod > PROD_SAT) scaled = 8'd255;
    else scaled = rounded[15:8];
  end
  assign cmd_data = (in_data.address == int_addr_r) ? scaled : in_data.data;

  assign b = (in_data.kind == KIND_RX) ? in_data.rx_byte : 8'h00;

  always_comb begin
    g_em = em_r && !rc_r[3] && (b == frame_byte(rc_r[2:0], fa_r, fd_r));
    if (ems_r < ERR_SEEN) begin
      if (b == error_char(ems_r)) g_ems = ems_r + 3'd1;
      else g_ems = (b == CHAR_E) ? 3'd1 : 3'd0;
    end else begin
      g_ems = ems_r;
    end
    g_rc   = (rc_r < REPLY_MAX) ? rc_r + 4'd1 : rc_r;
    g_done = (g_rc >= REPLY_MIN) && (b == CHAR_LF) && (prev_r == CHAR_CR);
    if (g_em && g_rc == FRAME_LEN) g_status = STAT_OK;
    else if (g_ems == ERR_SEEN) g_status = STAT_ERROR;
    else g_status = STAT_UNKNOWN;
  end

  assign lim = (retry_r == '0) ? 4'd1 : retry_r;

  always_comb begin
    fa_nxt     = fa_r;
    fd_nxt     = fd_r;
    await_nxt  = await_r;
    att_nxt    = att_r;
    rc_nxt     = rc_r;
    em_nxt     = em_r;
    ems_nxt    = ems_r;
    prev_nxt   = prev_r;
    push       = 1'b0;
    push_job   = '0;
    do_gather  = 1'b0;
    do_verdict = 1'b0;
    v_status   = STAT_OK;
    final_v    = 1'b0;
    if (fire) begin
      case (in_data.kind)
        KIND_SEND: begin
          fa_nxt    = in_data.address;
          fd_nxt    = cmd_data;
          await_nxt = 1'b1;
          att_nxt   = 4'd1;
          rc_nxt    = '0;
          em_nxt    = 1'b1;
          ems_nxt   = '0;
          prev_nxt  = '0;
          push      = 1'b1;
          push_job.frame_en = 1'b1;
          push_job.address  = in_data.address;
          push_job.data     = cmd_data;
        end
        KIND_RX: begin
          do_gather = await_r;
        end
        KIND_TIMEOUT: begin
          if (await_r) begin
            if (rc_r > FAIL_COUNT) begin
              do_verdict = 1'b1;
              v_status   = STAT_READ_FAIL;
            end else begin
              do_gather = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    if (do_gather) begin
      em_nxt   = g_em;
      ems_nxt  = g_ems;
      rc_nxt   = g_rc;
      prev_nxt = b;
      if (g_done) begin
        do_verdict = 1'b1;
        v_status   = g_status;
      end
    end
    if (do_verdict) begin
      final_v  = (v_status == STAT_OK) || (att_r >= lim);
      rc_nxt   = '0;
      em_nxt   = 1'b1;
      ems_nxt  = '0;
      prev_nxt = '0;
      push     = 1'b1;
      push_job.verdict_en = 1'b1;
      push_job.status     = v_status;
      push_job.address    = fa_r;
      push_job.data       = fd_r;
      if (final_v) begin
        await_nxt        = 1'b0;
        push_job.gave_up = (v_status != STAT_OK);
      end else begin
        att_nxt           = att_r + 4'd1;
        push_job.frame_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_r    <= '0;
      fd_r    <= '0;
      await_r <= 1'b0;
      att_r   <= '0;
      rc_r    <= '0;
      em_r    <= 1'b1;
      ems_r   <= '0;
      prev_r  <= '0;
    end else begin
      fa_r    <= fa_nxt;
      fd_r    <= fd_nxt;
      await_r <= await_nxt;
      att_r   <= att_nxt;
      rc_r    <= rc_nxt;
      em_r    <= em_nxt;
      ems_r   <= ems_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

FILE: hw/rtl/ahcl_queue.sv
module ahcl_queue import ahcl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output job_t head
);

  job_t                   mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_r, wr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_r, rd_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QUEUE_CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_r == rd_r)) else $error("pointers disagree with count");

endmodule

FILE: hw/rtl/ahcl_back.sv
module ahcl_back import ahcl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  job_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  logic [3:0] last_idx;
  logic [3:0] fpos;
  logic       advance;
  out_item_t  res;

  assign last_idx = head.frame_en ? (head.verdict_en ? 4'd8 : 4'd7) : 4'd0;
  assign fpos     = head.verdict_en ? step_r - 4'd1 : step_r;
  assign advance  = q_valid && (!out_valid_r || out_ready);
  assign pop      = advance && (step_r == last_idx);

  always_comb begin
    res = '0;
    if (head.verdict_en && step_r == '0) begin
      res.out_kind = OUT_VERDICT;
      res.status   = head.status;
      res.gave_up  = head.gave_up;
      res.last     = !head.frame_en;
    end else begin
      res.out_kind = OUT_TX;
      res.tx_byte  = frame_byte(fpos[2:0], head.address, head.data);
      res.last     = (fpos[2:0] == 3'd7);
    end
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
      step_nxt      = pop ? 4'd0 : step_r + 4'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/ascii_hex_command_link_unit.sv
// ASCII-hex command link, command side.
// in_valid/in_ready/in_data: one transaction per command, received byte or
//   read timeout. A command expands into eight frame bytes; a closing reply or
//   a late timeout gives one verdict, plus eight resent bytes on a retry.
// out_valid/out_ready/out_data: one result per transaction, last marks the
//   final result of an input item.
// cfg_valid/cfg_ready/cfg_index/cfg_data: register writes (gain, intensity
//   address, retry limit); always ready, index three is ignored.
// Structure: front classifies into a four-entry job queue, back expands jobs
//   into a registered output; the queue and the output register lie between an
//   input transaction and its first result. Throughput: one input per cycle
//   while the job queue has room; the back side emits one result per cycle
//   while out_ready allows, so a frame job yields eight or nine results.
// Reset (synchronous, rst_n low) restores register defaults, empties the
//   queue and drops any pending reply.
// When out_ready is low while out_valid is high the output holds, the back
//   side stops, and the front keeps accepting until the job queue is full.
module ascii_hex_command_link_unit import ahcl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  logic push;
  job_t push_job;
  logic pop;
  logic q_valid;
  logic q_full;
  job_t head;

  assign cfg_ready = 1'b1;

  ahcl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  ahcl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head     (head)
  );

  ahcl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
